### hdl/twfa_pkg.sv
// ----------------------------------------------------------------------------
// twfa_pkg: shared constants and types for the true wind pipeline
// Holds CORDIC stage count, arctangent table and the per-stage beat record.
// ----------------------------------------------------------------------------
package twfa_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int INV_GAIN      = 39797;
    localparam int SPEED_MAX     = 8191;
    localparam int DW            = 34;

    typedef logic signed [DW-1:0] vec_t;

    typedef struct packed {
        logic [11:0] travel_speed;
        logic [15:0] travel_heading;
        logic [15:0] apparent_angle;
        logic [15:0] compass_heading;
    } side_t;

    function automatic logic signed [33:0] atan_val(input int i);
        logic signed [33:0] r;
        begin
            case (i)
                0: r = 34'sd536870912;
                1: r = 34'sd316933406;
                2: r = 34'sd167458907;
                3: r = 34'sd85004756;
                4: r = 34'sd42667331;
                5: r = 34'sd21354465;
                6: r = 34'sd10680862;
                7: r = 34'sd5340245;
                8: r = 34'sd2670163;
                9: r = 34'sd1335087;
                10: r = 34'sd667544;
                11: r = 34'sd333772;
                12: r = 34'sd166886;
                13: r = 34'sd83443;
                14: r = 34'sd41722;
                15: r = 34'sd20861;
                16: r = 34'sd10430;
                17: r = 34'sd5215;
                18: r = 34'sd2608;
                19: r = 34'sd1304;
                20: r = 34'sd652;
                21: r = 34'sd326;
                22: r = 34'sd163;
                23: r = 34'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

### hdl/twfa_cordic.sv
// ----------------------------------------------------------------------------
// twfa_cordic: pipelined CORDIC, one stage register per iteration
// Rotation mode (drive z to zero) or vectoring mode (drive y to zero).
// out_w carries y in rotation mode and the accumulated angle in vectoring mode.
// ----------------------------------------------------------------------------
module twfa_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                vectoring,
    input  logic                in_valid,
    input  twfa_pkg::vec_t      in_x,
    input  twfa_pkg::vec_t      in_y,
    input  twfa_pkg::vec_t      in_z,
    input  twfa_pkg::side_t     in_side,
    output logic                out_valid,
    output twfa_pkg::vec_t      out_x,
    output twfa_pkg::vec_t      out_w,
    output twfa_pkg::side_t     out_side
);

    localparam int N = twfa_pkg::CORDIC_STAGES;

    twfa_pkg::vec_t  x_reg [1:N];
    twfa_pkg::vec_t  y_reg [1:N];
    twfa_pkg::vec_t  z_reg [1:N];
    twfa_pkg::side_t s_reg [1:N];
    logic            v_reg [1:N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic            pos;
        logic            dir;
        logic            v_cur;
        twfa_pkg::vec_t  x_cur, y_cur, z_cur;
        twfa_pkg::side_t s_cur;
        twfa_pkg::vec_t  x_next, y_next, z_next;

        if (i == 0) begin : g_head
            assign v_cur = in_valid;
            assign x_cur = in_x;
            assign y_cur = in_y;
            assign z_cur = in_z;
            assign s_cur = in_side;
        end else begin : g_body
            assign v_cur = v_reg[i];
            assign x_cur = x_reg[i];
            assign y_cur = y_reg[i];
            assign z_cur = z_reg[i];
            assign s_cur = s_reg[i];
        end

        always_comb begin
            pos = vectoring ? !y_cur[twfa_pkg::DW-1] : !z_cur[twfa_pkg::DW-1];
            dir = pos ^ vectoring;
            if (dir) begin
                x_next = x_cur - (y_cur >>> i);
                y_next = y_cur + (x_cur >>> i);
                z_next = z_cur - twfa_pkg::atan_val(i);
            end else begin
                x_next = x_cur + (y_cur >>> i);
                y_next = y_cur - (x_cur >>> i);
                z_next = z_cur + twfa_pkg::atan_val(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_cur;
            end
            if (en) begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
                s_reg[i+1] <= s_cur;
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_x     = x_reg[N];
    assign out_w     = vectoring ? z_reg[N] : y_reg[N];
    assign out_side  = s_reg[N];

endmodule

### hdl/true_wind_from_apparent_top.sv
// ----------------------------------------------------------------------------
// true_wind_from_apparent_top: apparent wind to true wind speed and bearing
//
// Channel  Dir  tdata (low bit first)                          tuser
// s_       in   apparent_speed[11:0] apparent_angle[15:0]      -
//               travel_speed[11:0] travel_heading[15:0]
//               compass_heading[15:0] (72 bits)
// m_       out  true_speed[12:0] true_bearing[15:0] (32 bits)  compass_mode
//
// One beat per cycle while m_ is not stalled. The path runs through a
// quarter-turn stage, the rotation CORDIC pipeline, a fold stage, the vectoring
// CORDIC pipeline, a gain multiply and a final bearing stage. Reset clears all
// valid bits and sets the threshold to 48. A stall on m_ freezes the whole
// pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module true_wind_from_apparent_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // apparent_speed, apparent_angle, travel_speed,
                                   // travel_heading, compass_heading
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // true_speed, true_bearing, zero pad
    output logic        m_tuser    // compass_mode
);

    localparam int DW = twfa_pkg::DW;

    logic [11:0] thr_reg;
    logic        en;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= 12'd48;
        else if (cfg_we) thr_reg <= cfg_wdata;
    end

    // stage 0: quarter turn and gain-scaled start vector
    logic [11:0] a_in;
    logic [1:0]  q;
    logic [15:0] r16;
    twfa_pkg::side_t side_in;
    logic [27:0] s_amp;

    always_comb begin
        a_in                    = s_tdata[11:0];
        side_in.apparent_angle  = s_tdata[27:12];
        side_in.travel_speed    = s_tdata[39:28];
        side_in.travel_heading  = s_tdata[55:40];
        side_in.compass_heading = s_tdata[71:56];
        q     = 2'(({2'b0, side_in.apparent_angle} + 18'h02000) >> 14);
        r16   = side_in.apparent_angle - {q, 14'b0};
        s_amp = {16'b0, a_in} * 28'(twfa_pkg::INV_GAIN);
    end

    logic            v0_reg;
    logic [27:0]     amp_reg;
    logic [1:0]      q_reg;
    logic [15:0]     r_reg;
    twfa_pkg::side_t side0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else if (en) v0_reg <= s_tvalid;
        if (en) begin
            amp_reg   <= s_amp;
            q_reg     <= q;
            r_reg     <= r16;
            side0_reg <= side_in;
        end
    end

    twfa_pkg::vec_t rx, ry, rz;
    always_comb begin
        rx = '0;
        ry = '0;
        case (q_reg)
            2'd0: rx = DW'(amp_reg);
            2'd1: ry = DW'(amp_reg);
            2'd2: rx = -DW'(amp_reg);
            2'd3: ry = -DW'(amp_reg);
            default: rx = '0;
        endcase
        rz = {{(DW-32){r_reg[15]}}, r_reg, 16'b0};
    end

    logic            v1;
    twfa_pkg::vec_t  cs, sn;
    twfa_pkg::side_t side1;

    twfa_cordic u_rot (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vectoring(1'b0), .in_valid(v0_reg),
        .in_x(rx), .in_y(ry), .in_z(rz), .in_side(side0_reg),
        .out_valid(v1), .out_x(cs), .out_w(sn), .out_side(side1)
    );

    // stage: form north/east and fold to right half-plane
    twfa_pkg::vec_t  fy;
    logic            v2_reg;
    twfa_pkg::vec_t  vx_reg, vy_reg, vz_reg;
    twfa_pkg::side_t side2_reg;

    assign fy = cs - {{(DW-28){1'b0}}, side1.travel_speed, 16'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1;
        if (en) begin
            side2_reg <= side1;
            if (fy[DW-1]) begin
                vx_reg <= -fy;
                vy_reg <= -sn;
                vz_reg <= DW'(34'sh080000000);
            end else begin
                vx_reg <= fy;
                vy_reg <= sn;
                vz_reg <= '0;
            end
        end
    end

    logic            v3;
    twfa_pkg::vec_t  mag, ang;
    twfa_pkg::side_t side3;

    twfa_cordic u_vec (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vectoring(1'b1), .in_valid(v2_reg),
        .in_x(vx_reg), .in_y(vy_reg), .in_z(vz_reg), .in_side(side2_reg),
        .out_valid(v3), .out_x(mag), .out_w(ang), .out_side(side3)
    );

    // stage: gain multiply
    logic            v4_reg;
    logic [49:0]     prod_reg;
    logic            magpos_reg;
    logic [31:0]     ang_reg;
    twfa_pkg::side_t side4_reg;
    logic [33:0]     mag_u;

    assign mag_u = mag[DW-1] ? '0 : 34'(mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3;
        if (en) begin
            prod_reg   <= {16'b0, mag_u} * 50'(twfa_pkg::INV_GAIN);
            magpos_reg <= !mag[DW-1] && (mag != '0);
            ang_reg    <= ang[31:0];
            side4_reg  <= side3;
        end
    end

    // stage: round, saturate, bearing select
    logic [50:0] rnd;
    logic [18:0] spd_w;
    logic [12:0] spd;
    logic        cmode;
    logic [15:0] brg;

    always_comb begin
        rnd   = {1'b0, prod_reg} + 51'h080000000;
        spd_w = magpos_reg ? rnd[50:32] : '0;
        spd   = (spd_w > 19'(twfa_pkg::SPEED_MAX)) ? 13'(twfa_pkg::SPEED_MAX) : spd_w[12:0];
        cmode = side4_reg.travel_speed < thr_reg;
        if (cmode)
            brg = side4_reg.apparent_angle + side4_reg.compass_heading;
        else if (spd == '0)
            brg = '0;
        else
            brg = side4_reg.travel_heading + 16'((33'(ang_reg) + 33'h8000) >> 16);
    end

    logic        out_v_reg;
    logic [12:0] spd_reg;
    logic [15:0] brg_reg;
    logic        mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= v4_reg;
        if (en) begin
            spd_reg  <= spd;
            brg_reg  <= brg;
            mode_reg <= cmode;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {3'b0, brg_reg, spd_reg};
    assign m_tuser  = mode_reg;

endmodule

### tb/true_wind_checker.sv
// ----------------------------------------------------------------------------
// true_wind_checker: scoreboard for the true wind pipeline
// Watches both stream channels, predicts speed, bearing and mode for every
// accepted input beat and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
module true_wind_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [12:0] speed;
        logic [15:0] bearing;
        logic        mode;
    } wind_t;

    wind_t       wind_q[$];
    logic [11:0] threshold;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint tab [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        return tab[i];
    endfunction

    function automatic wind_t predict_wind(logic [71:0] d, logic [11:0] thr);
        longint    a, t, x, y, z, nx, ny, s, north, east, mag;
        logic [31:0] a32, r32, q, ang;
        logic [15:0] aa, th, ch;
        logic [63:0] spd;
        wind_t     w;
        a  = d[11:0];
        aa = d[27:12];
        t  = d[39:28];
        th = d[55:40];
        ch = d[71:56];
        a32 = {aa, 16'h0};
        q   = ((a32 + 32'h2000_0000) >> 30) & 32'd3;
        r32 = a32 - (q << 30);
        z   = longint'($signed(r32));
        s   = a * twfa_pkg::INV_GAIN;
        x = 0;
        y = 0;
        case (q)
            0: x = s;
            1: y = s;
            2: x = -s;
            default: y = -s;
        endcase
        for (int i = 0; i < twfa_pkg::CORDIC_STAGES; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= atan_entry(i);
            end else begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += atan_entry(i);
            end
            x = nx;
            y = ny;
        end
        north = x - t * 65536;
        east  = y;
        x = north;
        y = east;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'h8000_0000;
        end
        for (int i = 0; i < twfa_pkg::CORDIC_STAGES; i++) begin
            if (y >= 0) begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += atan_entry(i);
            end else begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= atan_entry(i);
            end
            x = nx;
            y = ny;
        end
        mag = x;
        ang = z[31:0];
        if (mag <= 0) spd = 0;
        else spd = (64'(mag) * twfa_pkg::INV_GAIN + 64'h8000_0000) >> 32;
        if (spd > twfa_pkg::SPEED_MAX) spd = twfa_pkg::SPEED_MAX;
        w.speed = spd[12:0];
        if (t < thr) begin
            w.mode    = 1'b1;
            w.bearing = aa + ch;
        end else begin
            w.mode    = 1'b0;
            w.bearing = (spd == 0) ? 16'd0 : 16'(th + ((ang + 32'h8000) >> 16));
        end
        return w;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        wind_t w;
        if (!aresetn) begin
            threshold <= 12'd48;
        end else begin
            if (m_tvalid && m_tready) begin
                if (wind_q.size() == 0) begin
                    report("unexpected beat", m_tdata[12:0], -1);
                end else begin
                    w = wind_q.pop_front();
                    if (m_tdata[12:0] !== w.speed) report("true_speed", m_tdata[12:0], w.speed);
                    if (m_tdata[28:13] !== w.bearing)
                        report("true_bearing", m_tdata[28:13], w.bearing);
                    if (m_tuser !== w.mode) report("compass_mode", m_tuser, w.mode);
                end
            end
            if (s_tvalid && s_tready) wind_q.push_back(predict_wind(s_tdata, threshold));
            if (cfg_we) threshold <= cfg_wdata;
        end
        pending = wind_q.size();
    end
endmodule

### tb/tb_true_wind_from_apparent_top.sv
// ----------------------------------------------------------------------------
// tb_true_wind_from_apparent_top: stimulus for the true wind pipeline
// Directed corner samples, then random samples under several thresholds, with
// random gaps on m_, on s_ in most phases; a checker scores every output beat.
// ----------------------------------------------------------------------------
module tb_true_wind_from_apparent_top;
    localparam int LATENCY = 2 * twfa_pkg::CORDIC_STAGES + 4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending;
    int          rx_wait = 0;
    bit          stim_done = 0;

    always #1 aclk = ~aclk;

    true_wind_from_apparent_top dut (.*);
    true_wind_checker chk (.*);

    task automatic send_sample(logic [11:0] spd, logic [15:0] aa, logic [11:0] ts,
                               logic [15:0] th, logic [15:0] ch, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ch, th, ts, aa, spd};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_and_write(logic [11:0] thr);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n, bit gaps);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: send_sample(12'($urandom), 16'($urandom), 12'($urandom_range(0, 80)),
                               16'($urandom), 16'($urandom), gaps);
                1: send_sample(12'($urandom_range(4032, 4095)), 16'($urandom),
                               12'($urandom_range(4032, 4095)), 16'($urandom),
                               16'($urandom), gaps);
                2: begin
                    logic [11:0] v;
                    v = 12'($urandom);
                    send_sample(v, 16'($urandom_range(0, 3) * 16384), v, 16'($urandom),
                                16'($urandom), gaps);
                end
                default: send_sample(12'($urandom), 16'($urandom), 12'($urandom),
                                     16'($urandom), 16'($urandom), gaps);
            endcase
        end
    endtask

    always @(posedge aclk) begin
        int w;
        w = $urandom_range(0, 15);
        if (!aresetn || stim_done) begin
            m_tready <= 1'b1;
            rx_wait  <= 0;
        end else if (rx_wait != 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else if (m_tvalid && m_tready) begin
            rx_wait  <= w;
            m_tready <= (w == 0);
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(4095, 16'hFFFF, 4095, 16'hFFFF, 16'hFFFF, 0);
        send_sample(4095, 0, 4095, 0, 0, 0);
        send_sample(160, 16'h8000, 160, 16'h4000, 0, 0);
        send_sample(100, 0, 100, 16'h1234, 0, 0);
        send_sample(4095, 16'h8000, 0, 0, 0, 0);
        send_sample(0, 0, 47, 0, 16'hFFFF, 0);
        send_sample(300, 16'hC000, 47, 16'h2000, 16'h8001, 0);
        send_sample(300, 16'h4000, 48, 16'h2000, 16'h8001, 0);
        send_sample(0, 16'h5555, 48, 16'hAAAA, 16'h5555, 0);
        send_sample(1, 16'h2000, 0, 16'h7FFF, 0, 0);
        send_sample(2048, 16'h6000, 1024, 16'hE000, 16'h1111, 0);
        random_phase(250, 1);
        drain_and_write(12'd0);
        send_sample(10, 16'h1000, 0, 16'h3000, 16'h4000, 0);
        random_phase(250, 0);
        drain_and_write(12'd4095);
        send_sample(10, 16'h1000, 4094, 16'h3000, 16'h4000, 0);
        send_sample(10, 16'h1000, 4095, 16'h3000, 16'h4000, 0);
        random_phase(300, 1);
        drain_and_write(12'($urandom_range(1, 4094)));
        random_phase(320, 1);
        s_tvalid <= 1'b0;
        stim_done = 1;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### files.f
hdl/twfa_pkg.sv
hdl/twfa_cordic.sv
hdl/true_wind_from_apparent_top.sv
tb/true_wind_checker.sv
tb/tb_true_wind_from_apparent_top.sv
